>>> rtl/nnsag_pkg.sv
// ----------------------------------------------------------------------------
// nnsag_pkg
// shared widths, register indexes and dimension helpers for the nv12
// nearest-neighbor scale address generator
// ----------------------------------------------------------------------------
`default_nettype none

package nnsag_pkg;

    localparam int DIM_W    = 13;   // configuration register width
    localparam int CNT_W    = 12;   // block counters, coordinates, quotients
    localparam int PROD_W   = 25;   // serial multiplier product width
    localparam int STEP_W   = 4;    // serial step counter width
    localparam int LUMA_W   = 24;
    localparam int CHROMA_W = 23;
    localparam int REG_IDX_W = 2;

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

    // one multiplier bit or one quotient bit per step
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = REG_IDX_W'(3);

    localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = DIM_W'(480);
    localparam logic [DIM_W-1:0] RST_DST_WIDTH  = DIM_W'(160);
    localparam logic [DIM_W-1:0] RST_DST_HEIGHT = DIM_W'(120);

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        sat_dim = (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic logic [DIM_W-1:0] tgt_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = sat_dim(v) & ~DIM_W'(1);
        tgt_dim = (d == '0) ? DIM_W'(2) : d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/nnsag_if.sv
// ----------------------------------------------------------------------------
// nnsag channel interfaces
// valid/ready channels for requests, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface nnsag_item_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface nnsag_result_if;
    import nnsag_pkg::*;
    logic                valid;
    logic                ready;
    logic [LUMA_W-1:0]   src_luma_offset;
    logic [CHROMA_W-1:0] src_chroma_offset;
    logic [LUMA_W-1:0]   dst_luma_offset;
    logic [CHROMA_W-1:0] dst_chroma_offset;
    logic                last_block;

    modport source (output valid, output src_luma_offset, output src_chroma_offset,
                    output dst_luma_offset, output dst_chroma_offset,
                    output last_block, input ready);
    modport sink   (input valid, input src_luma_offset, input src_chroma_offset,
                    input dst_luma_offset, input dst_chroma_offset,
                    input last_block, output ready);
endinterface

interface nnsag_cfg_if;
    import nnsag_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/nnsag_mul.sv
// ----------------------------------------------------------------------------
// nnsag_mul
// bit-serial shift-add multiplier, 13 x 12 bits, one multiplier bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module nnsag_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [nnsag_pkg::DIM_W-1:0]   mcand,
    input  wire logic [nnsag_pkg::CNT_W-1:0]   mplier,
    output logic      [nnsag_pkg::PROD_W-1:0]  product,
    output logic                               done
);
    import nnsag_pkg::*;

    // {carry, high accumulator, remaining multiplier bits}
    logic [DIM_W+CNT_W:0]   p_reg,     p_next;
    logic [DIM_W-1:0]       mcand_reg;
    logic [STEP_W-1:0]      cnt_reg,   cnt_next;
    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;
    logic [DIM_W:0]         sum;

    always_comb
    begin
        sum       = p_reg[DIM_W+CNT_W:CNT_W]
                  + (p_reg[0] ? {1'b0, mcand_reg} : '0);
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            p_next    = {{(DIM_W+1){1'b0}}, mplier};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next   = {1'b0, sum, p_reg[CNT_W-1:1]};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (start)
        begin
            mcand_reg <= mcand;
        end
    end

    assign product = p_reg[PROD_W-1:0];
    assign done    = done_reg;

endmodule

`default_nettype wire

>>> rtl/nnsag_div.sv
// ----------------------------------------------------------------------------
// nnsag_div
// bit-serial restoring divider, 25-bit dividend by 13-bit divisor,
// one quotient bit a cycle; the quotient is known to fit in 12 bits
// ----------------------------------------------------------------------------
`default_nettype none

module nnsag_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [nnsag_pkg::PROD_W-1:0]  num,
    input  wire logic [nnsag_pkg::DIM_W-1:0]   den,
    output logic      [nnsag_pkg::CNT_W-1:0]   quot,
    output logic                               done
);
    import nnsag_pkg::*;

    logic [DIM_W-1:0]   rem_reg,  rem_next;
    logic [CNT_W-1:0]   q_reg,    q_next;
    logic [DIM_W-1:0]   den_reg;
    logic [STEP_W-1:0]  cnt_reg,  cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIM_W:0]     trial;
    logic [DIM_W+1:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, q_reg[CNT_W-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // upper bits already below the divisor: skip those steps
            rem_next  = num[PROD_W-1:CNT_W];
            q_next    = num[CNT_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIM_W+1])
            begin
                rem_next = diff[DIM_W-1:0];
                q_next   = {q_reg[CNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIM_W-1:0];
                q_next   = {q_reg[CNT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

>>> rtl/nv12_nearest_scale_addr_gen.sv
// ----------------------------------------------------------------------------
// nv12_nearest_scale_addr_gen
// buffer offset generator for nearest-neighbor downscaling of an nv12 frame,
// one 2x2 thumbnail block per request in raster order
// ----------------------------------------------------------------------------
// each request steps through multiply, divide, multiply and finish states
// throughput: one block at a time, set by three back-to-back 12-step
//   serial passes (multiply, divide, multiply) one bit per cycle
// a finished result waits in the output register while the next request runs
// reset: registers go to 640x480 source and 160x120 target, block counters
//   to the first block, no result pending
`default_nettype none

module nv12_nearest_scale_addr_gen (
    input  wire logic     clk,
    input  wire logic     rst_n,
    nnsag_item_if.sink    item,
    nnsag_result_if.source result,
    nnsag_cfg_if.sink     cfg
);
    import nnsag_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_DIV,
        ST_MUL2,
        ST_FIN
    } state_t;

    // configuration registers
    logic [DIM_W-1:0] src_width_reg;
    logic [DIM_W-1:0] src_height_reg;
    logic [DIM_W-1:0] dst_width_reg;
    logic [DIM_W-1:0] dst_height_reg;

    // effective dimensions
    logic [DIM_W-1:0] sw, sh, tw, th;
    logic [CNT_W-1:0] cols, rows;

    // block position bookkeeping
    state_t             state_reg;
    logic [CNT_W-1:0]   bc_reg, br_reg;
    logic [CNT_W-1:0]   c0, r0, c1, r1, r2, cn, rn, rn0;
    logic               last_cur;
    logic [CNT_W-1:0]   x_reg, y_reg;
    logic [CNT_W-2:0]   brow_reg;
    logic               last_reg;
    logic               mul_start_reg;
    logic               div_start_reg;
    logic               accept;

    // serial units
    logic [DIM_W-1:0]   m0_a, m1_a;
    logic [CNT_W-1:0]   m0_b, m1_b;
    logic [PROD_W-1:0]  m0_p, m1_p, m2_p, m3_p;
    logic               m0_done, m1_done, m2_done, m3_done;
    logic               start_dst;
    logic [PROD_W-1:0]  num_row, num_col;
    logic [CNT_W-1:0]   srow, scol;
    logic               d0_done, d1_done;
    logic               mul1_fin, div_fin;

    // result register
    logic                out_valid_reg;
    logic [LUMA_W-1:0]   src_luma_reg;
    logic [CHROMA_W-1:0] src_chroma_reg;
    logic [LUMA_W-1:0]   dst_luma_reg;
    logic [CHROMA_W-1:0] dst_chroma_reg;
    logic                last_out_reg;
    logic                out_load;

    // ------------------------------------------------------------------
    // register writes, always ready
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            dst_width_reg  <= RST_DST_WIDTH;
            dst_height_reg <= RST_DST_HEIGHT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg.data;
                REG_SRC_HEIGHT: src_height_reg <= cfg.data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg.data;
                REG_DST_HEIGHT: dst_height_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // saturate to the max dimension, force target sizes even and nonzero
    assign sw   = sat_dim(src_width_reg);
    assign sh   = sat_dim(src_height_reg);
    assign tw   = tgt_dim(dst_width_reg);
    assign th   = tgt_dim(dst_height_reg);
    assign cols = tw[DIM_W-1:1];
    assign rows = th[DIM_W-1:1];

    // ------------------------------------------------------------------
    // block position at the request transfer
    // ------------------------------------------------------------------
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        // restart, then pull a stale position back inside the frame
        c0  = item.restart ? '0 : bc_reg;
        r0  = item.restart ? '0 : br_reg;
        c1  = (c0 >= cols) ? '0 : c0;
        r1  = (c0 >= cols) ? r0 + CNT_W'(1) : r0;
        r2  = (r1 >= rows) ? '0 : r1;
        last_cur = (c1 == cols - CNT_W'(1)) && (r2 == rows - CNT_W'(1));
        // advance to the next block, wrapping at the end of the frame
        cn  = c1 + CNT_W'(1);
        rn0 = r2 + CNT_W'(1);
        rn  = r2;
        if (cn >= cols)
        begin
            cn = '0;
            rn = (rn0 >= rows) ? '0 : rn0;
        end
    end

    // ------------------------------------------------------------------
    // serial datapath
    // pass 1: sh*y, sw*x, tw*y, tw*(y/2)
    // pass 2: source row and column, rounded to nearest
    // pass 3: srow*sw, (srow/2)*sw
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_MUL2)
        begin
            m0_a = sw;
            m0_b = srow;
            m1_a = sw;
            m1_b = {1'b0, srow[CNT_W-1:1]};
        end
        else
        begin
            m0_a = sh;
            m0_b = y_reg;
            m1_a = sw;
            m1_b = x_reg;
        end
    end

    assign start_dst = mul_start_reg && (state_reg == ST_MUL1);

    nnsag_mul u_mul_srow (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .mcand   (m0_a),
        .mplier  (m0_b),
        .product (m0_p),
        .done    (m0_done)
    );

    nnsag_mul u_mul_scol (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .mcand   (m1_a),
        .mplier  (m1_b),
        .product (m1_p),
        .done    (m1_done)
    );

    nnsag_mul u_mul_dluma (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_dst),
        .mcand   (tw),
        .mplier  (y_reg),
        .product (m2_p),
        .done    (m2_done)
    );

    nnsag_mul u_mul_dchroma (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_dst),
        .mcand   (tw),
        .mplier  ({1'b0, brow_reg}),
        .product (m3_p),
        .done    (m3_done)
    );

    // add half the divisor so the quotient rounds to nearest
    assign num_row = m0_p + {{(PROD_W-CNT_W){1'b0}}, th[DIM_W-1:1]};
    assign num_col = m1_p + {{(PROD_W-CNT_W){1'b0}}, tw[DIM_W-1:1]};

    nnsag_div u_div_row (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_row),
        .den   (th),
        .quot  (srow),
        .done  (d0_done)
    );

    nnsag_div u_div_col (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_col),
        .den   (tw),
        .quot  (scol),
        .done  (d1_done)
    );

    // ------------------------------------------------------------------
    // sequencer and result register
    // ------------------------------------------------------------------
    // all four first-pass products finish together
    assign mul1_fin = (state_reg == ST_MUL1) && m0_done && m1_done && m2_done && m3_done;
    assign div_fin  = (state_reg == ST_DIV) && d0_done && d1_done;
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            br_reg        <= '0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= accept || div_fin;
            div_start_reg <= mul1_fin;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        bc_reg    <= cn;
                        br_reg    <= rn;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    if (mul1_fin)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_fin)
                    begin
                        state_reg <= ST_MUL2;
                    end
                end
                ST_MUL2:
                begin
                    if (m0_done && m1_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // block coordinates and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= {c1[CNT_W-2:0], 1'b0};
            y_reg    <= {r2[CNT_W-2:0], 1'b0};
            brow_reg <= r2[CNT_W-2:0];
            last_reg <= last_cur;
        end
        if (out_load)
        begin
            src_luma_reg   <= m0_p[LUMA_W-1:0] + {{(LUMA_W-CNT_W){1'b0}}, scol};
            src_chroma_reg <= m1_p[CHROMA_W-1:0]
                            + {{(CHROMA_W-CNT_W){1'b0}}, scol[CNT_W-1:1], 1'b0};
            dst_luma_reg   <= m2_p[LUMA_W-1:0] + {{(LUMA_W-CNT_W){1'b0}}, x_reg};
            dst_chroma_reg <= m3_p[CHROMA_W-1:0] + {{(CHROMA_W-CNT_W){1'b0}}, x_reg};
            last_out_reg   <= last_reg;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.src_luma_offset   = src_luma_reg;
    assign result.src_chroma_offset = src_chroma_reg;
    assign result.dst_luma_offset   = dst_luma_reg;
    assign result.dst_chroma_offset = dst_chroma_reg;
    assign result.last_block        = last_out_reg;

endmodule

`default_nettype wire

>>> tb/nnsag_checker.sv
// ----------------------------------------------------------------------------
// nnsag_checker
// watches the request, result and register channels of the nv12 scale
// address generator, predicts each block's offsets and compares them
// ----------------------------------------------------------------------------
module nnsag_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    nnsag_item_if     item,
    nnsag_result_if   result,
    nnsag_cfg_if      cfg,
    output int        outstanding,
    output int        mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import nnsag_pkg::*;

    localparam longint unsigned DIM_CAP = 4096;
    localparam int PRINT_CAP = 40;

    typedef struct {
        logic [LUMA_W-1:0]   src_luma;
        logic [CHROMA_W-1:0] src_chroma;
        logic [LUMA_W-1:0]   dst_luma;
        logic [CHROMA_W-1:0] dst_chroma;
        logic                last;
    } block_offsets_t;

    // shadow of the frame registers and the block scan position
    logic [DIM_W-1:0] frame_sw, frame_sh, frame_tw, frame_th;
    longint unsigned  scan_col, scan_row;

    block_offsets_t offsets_due[$];
    block_offsets_t want;

    function automatic longint unsigned clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_CAP) ? DIM_CAP : longint'(v);
    endfunction

    // target sizes are forced even and never below two
    function automatic longint unsigned even_target(input logic [DIM_W-1:0] v);
        longint unsigned d;
        d = clamp_dim(v) & ~64'd1;
        return (d == 0) ? 64'd2 : d;
    endfunction

    function automatic block_offsets_t next_block_offsets(input logic restart);
        longint unsigned sw, sh, tw, th, cols, rows, x, y, srow, scol;
        block_offsets_t b;
        sw   = clamp_dim(frame_sw);
        sh   = clamp_dim(frame_sh);
        tw   = even_target(frame_tw);
        th   = even_target(frame_th);
        cols = tw / 2;
        rows = th / 2;
        if (restart)
        begin
            scan_col = 0;
            scan_row = 0;
        end
        // position may lie outside a frame that was shrunk
        if (scan_col >= cols)
        begin
            scan_col = 0;
            scan_row++;
        end
        if (scan_row >= rows)
            scan_row = 0;
        x    = scan_col * 2;
        y    = scan_row * 2;
        srow = (sh * y + th / 2) / th;
        scol = (sw * x + tw / 2) / tw;
        b.src_luma   = LUMA_W'(srow * sw + scol);
        b.src_chroma = CHROMA_W'((srow / 2) * sw + (scol / 2) * 2);
        b.dst_luma   = LUMA_W'(y * tw + x);
        b.dst_chroma = CHROMA_W'((y / 2) * tw + x);
        b.last       = (scan_col == cols - 1) && (scan_row == rows - 1);
        scan_col++;
        if (scan_col >= cols)
        begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= rows)
                scan_row = 0;
        end
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_sw    = RST_SRC_WIDTH;
            frame_sh    = RST_SRC_HEIGHT;
            frame_tw    = RST_DST_WIDTH;
            frame_th    = RST_DST_HEIGHT;
            scan_col    = 0;
            scan_row    = 0;
            offsets_due.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (offsets_due.size() == 0)
                    report_mismatch($sformatf("result with nothing pending, src luma 0x%0h",
                                              result.src_luma_offset));
                else
                begin
                    want = offsets_due.pop_front();
                    if (result.src_luma_offset !== want.src_luma)
                        report_mismatch($sformatf("src luma 0x%0h, expected 0x%0h",
                                                  result.src_luma_offset, want.src_luma));
                    if (result.src_chroma_offset !== want.src_chroma)
                        report_mismatch($sformatf("src chroma 0x%0h, expected 0x%0h",
                                                  result.src_chroma_offset, want.src_chroma));
                    if (result.dst_luma_offset !== want.dst_luma)
                        report_mismatch($sformatf("dst luma 0x%0h, expected 0x%0h",
                                                  result.dst_luma_offset, want.dst_luma));
                    if (result.dst_chroma_offset !== want.dst_chroma)
                        report_mismatch($sformatf("dst chroma 0x%0h, expected 0x%0h",
                                                  result.dst_chroma_offset, want.dst_chroma));
                    if (result.last_block !== want.last)
                        report_mismatch($sformatf("last block %b, expected %b",
                                                  result.last_block, want.last));
                end
            end
            if (item.valid && item.ready)
                offsets_due.push_back(next_block_offsets(item.restart));
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SRC_WIDTH:  frame_sw = cfg.data;
                    REG_SRC_HEIGHT: frame_sh = cfg.data;
                    REG_DST_WIDTH:  frame_tw = cfg.data;
                    REG_DST_HEIGHT: frame_th = cfg.data;
                    default: ;
                endcase
            end
            outstanding = offsets_due.size();
        end
    end

endmodule

>>> tb/tb_nv12_nearest_scale_addr_gen.sv
// ----------------------------------------------------------------------------
// tb_nv12_nearest_scale_addr_gen
// drives block requests and frame register writes into the nv12 scale
// address generator with random stalls on both sides; the checker beside the
// block predicts every block's offsets and counts mismatches
// ----------------------------------------------------------------------------
module tb_nv12_nearest_scale_addr_gen;
    timeunit 1ns;
    timeprecision 1ps;

    import nnsag_pkg::*;

    localparam int CLK_HALF_NS      = 2;
    localparam int RESET_CYCLES     = 6;
    localparam int BLOCK_LATENCY    = 43;              // request to result, per the rtl
    localparam int SETTLE_CYCLES    = BLOCK_LATENCY + 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 500;
    localparam int CALM_ITEMS       = 60;              // tail of the run with no idling
    localparam int TIMEOUT_NS       = 2_000_000;

    logic clk = 1'b0;
    logic rst_n;

    nnsag_item_if   item_ch();
    nnsag_result_if result_ch();
    nnsag_cfg_if    cfg_ch();

    int chk_outstanding;
    int chk_mismatches;

    // knobs for the request driver and the result sink
    bit sender_choppy;
    bit sink_choppy;
    bit long_hold;
    bit calm;

    nv12_nearest_scale_addr_gen uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    nnsag_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .outstanding (chk_outstanding),
        .mismatches  (chk_mismatches)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // run limit, far above the slowest legal run
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // result sink: ready runs, random stall bursts, and one long hold-off that
    // lets the block fill up and push back on requests
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            if (long_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!calm && sink_choppy && $urandom_range(0, 2) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // one block request; valid stays high across back-to-back transfers and
    // only drops for a sender gap
    task automatic send_block_req(input logic restart);
        if (!calm && sender_choppy && $urandom_range(0, 2) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.restart <= restart;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // stop requesting, wait for every pending block, then let the pipe settle
    task automatic close_phase();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (chk_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // all four frame registers, written back to back while the block is idle
    task automatic program_frame(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                 input logic [DIM_W-1:0] tw, input logic [DIM_W-1:0] th);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, tw);
        write_reg(REG_DST_HEIGHT, th);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int phase;
        int burst;
        logic [DIM_W-1:0] sw, sh, tw, th;

        item_ch.valid   = 1'b0;
        item_ch.restart = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_SRC_WIDTH;
        cfg_ch.data     = '0;
        sender_choppy   = 1'b0;
        sink_choppy     = 1'b0;
        long_hold       = 1'b0;
        calm            = 1'b0;
        rst_n           = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // reset frame 640x480 into 160x120, continue, restart, continue
        send_block_req(1'b0);
        send_block_req(1'b1);
        send_block_req(1'b0);
        close_phase();

        // every size above the cap saturates, odd target cleared to 4096
        program_frame(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        send_block_req(1'b1);
        send_block_req(1'b0);
        send_block_req(1'b0);
        close_phase();

        // zero source, target of one and zero becomes 2x2; the scan position
        // left over from the wide frame lies past the single block
        program_frame(13'd0, 13'd0, 13'd1, 13'd0);
        send_block_req(1'b0);
        send_block_req(1'b0);
        send_block_req(1'b1);
        close_phase();

        // odd target 7x5 runs as 6x4: six blocks, wrap after the last
        program_frame(13'd4096, 13'd4096, 13'd7, 13'd5);
        repeat (8) send_block_req(1'b0);
        close_phase();

        // tiny source into the largest target
        program_frame(13'd2, 13'd2, 13'd4096, 13'd2);
        send_block_req(1'b1);
        send_block_req(1'b0);
        send_block_req(1'b0);
        close_phase();

        // odd source width, tall target
        program_frame(13'd1, 13'd4095, 13'd4, 13'd8190);
        repeat (4) send_block_req(1'b0);
        close_phase();

        // ---- random part ----
        // mostly small thumbnails so frames wrap often; restarts are rare so
        // the scan position usually carries across a frame change
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase != 0 && $urandom_range(0, 4) != 0)
            begin
                sw = $urandom_range(0, 1) ? 13'($urandom_range(0, 8191))
                                          : 13'($urandom_range(2, 64));
                sh = $urandom_range(0, 1) ? 13'($urandom_range(0, 8191))
                                          : 13'($urandom_range(2, 64));
                tw = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(0, 24));
                th = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(0, 24));
                program_frame(sw, sh, tw, th);
            end
            sender_choppy = ($urandom_range(0, 3) != 0);
            sink_choppy   = ($urandom_range(0, 3) != 0);
            burst         = $urandom_range(8, 40);
            if (phase == 2)
            begin
                // hold the sink off while requests keep coming
                long_hold     = 1'b1;
                sender_choppy = 1'b0;
                burst         = 16;
            end
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            repeat (burst)
            begin
                send_block_req($urandom_range(0, 15) == 0);
                sent++;
            end
            close_phase();
            phase++;
        end

        if (chk_mismatches == 0 && chk_outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/nnsag_pkg.sv
rtl/nnsag_if.sv
rtl/nnsag_mul.sv
rtl/nnsag_div.sv
rtl/nv12_nearest_scale_addr_gen.sv
tb/nnsag_checker.sv
tb/tb_nv12_nearest_scale_addr_gen.sv
